>>> design/tcpq_pkg.sv
`default_nettype none

package tcpq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 16;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 7;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] entry_key;
        logic             fast_class;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [OCC_W-1:0] occupancy;
        logic             head_valid;
        logic [KEY_W-1:0] head_key;
        logic             head_fast;
    } t_out_item;

    // contents of one queue position
    typedef struct packed {
        logic             valid;
        logic             fast;
        logic [KEY_W-1:0] key;
    } t_slot;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             capture;
        logic             hit_cmd;
        logic [KEY_W-1:0] hit_key;
        logic             hit_fast;
        logic             apply;
        logic             app_cmd;
        logic [KEY_W-1:0] app_key;
        logic             app_fast;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> design/tcpq_cell.sv
`default_nettype none

module tcpq_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tcpq_pkg::t_cell_ctrl i_ctrl,
    input  wire tcpq_pkg::t_slot    i_left,
    input  wire tcpq_pkg::t_slot    i_right,
    input  wire logic               i_ge_self,
    input  wire logic               i_ge_left,
    output tcpq_pkg::t_slot         o_slot,
    output logic                    o_hit
);
    import tcpq_pkg::*;

    logic  r_valid;
    logic  r_fast;
    logic  [KEY_W-1:0] r_key;
    logic  r_hit;
    t_slot n_slot;
    logic  n_hit;

    // hit: for remove, a matching key; for insert, position at or behind the insert point
    always_comb begin
        n_hit = r_hit;
        if (i_ctrl.capture) begin
            if (i_ctrl.hit_cmd == CMD_REMOVE) begin
                n_hit = r_valid && (r_key == i_ctrl.hit_key);
            end else if (i_ctrl.hit_fast) begin
                n_hit = !(r_valid && r_fast);
            end else begin
                n_hit = !r_valid;
            end
        end
    end

    always_comb begin
        n_slot = '{valid: r_valid, fast: r_fast, key: r_key};
        if (i_ctrl.apply && i_ge_self) begin
            if (i_ctrl.app_cmd == CMD_REMOVE) begin
                n_slot = i_right;
            end else if (i_ge_left) begin
                n_slot = i_left;
            end else begin
                n_slot = '{valid: 1'b1, fast: i_ctrl.app_fast, key: i_ctrl.app_key};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fast <= n_slot.fast;
        r_key  <= n_slot.key;
    end

    assign o_slot = '{valid: r_valid, fast: r_fast, key: r_key};
    assign o_hit  = r_hit;

endmodule

`default_nettype wire

>>> design/two_class_priority_queue.sv
`default_nettype none

// two-class priority queue built as a row of CAPACITY cells, position 0 at the head.
// fast entries always stand ahead of regular ones, fifo order within each class.
// in every transaction, at the accept edge each cell registers its own
// compare (key match for remove, class/occupancy test for insert); in the apply state
// the first hit is isolated over the row with one add and every cell at or behind it
// shifts by one toward or away from the head in a single step. a new transaction is only
// accepted after the apply state of the previous one, that state stretching only while
// a previous result still waits on the output register. each result carries the status,
// occupancy and head entry after the transaction; insert into a full queue reports full
// and changes nothing, remove of an absent key or from an empty queue reports not found.
module two_class_priority_queue #(
    parameter int CAPACITY = tcpq_pkg::CAPACITY_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // command channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tcpq_pkg::t_in_item  i_in_data,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tcpq_pkg::t_out_item      o_out_data
);
    import tcpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_state;

    t_state           r_state, n_state;
    t_in_item         r_item;
    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_status, n_status;
    logic             r_out_valid, n_out_valid;

    t_cell_ctrl       w_ctrl;
    t_slot            w_slot [CAPACITY];
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_ge;
    logic             w_accept;
    logic             w_step;
    logic             w_full;
    logic             w_found;

    assign w_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // the apply state may retire only when the output register is free or being read
    assign w_step = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_found = |w_hit;

    // all positions at or behind the lowest hit: x | -x
    assign w_ge = w_hit | (~w_hit + {{(CAPACITY-1){1'b0}}, 1'b1});

    always_comb begin
        w_ctrl.capture  = w_accept;
        w_ctrl.hit_cmd  = i_in_data.cmd;
        w_ctrl.hit_key  = i_in_data.entry_key;
        w_ctrl.hit_fast = i_in_data.fast_class;
        // a full insert leaves the row untouched
        w_ctrl.apply    = w_step && !((r_item.cmd == CMD_INSERT) && w_full);
        w_ctrl.app_cmd  = r_item.cmd;
        w_ctrl.app_key  = r_item.entry_key;
        w_ctrl.app_fast = r_item.fast_class;
    end

    // cell row, each cell sees its neighbors on both sides
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_ge_left;

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_ge_left = 1'b0;
        end else begin : g_mid
            assign w_left    = w_slot[g-1];
            assign w_ge_left = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_slot[g+1];
        end

        tcpq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_left    (w_left),
            .i_right   (w_right),
            .i_ge_self (w_ge[g]),
            .i_ge_left (w_ge_left),
            .o_slot    (w_slot[g]),
            .o_hit     (w_hit[g])
        );
    end

    // sequencer, status and occupancy
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_step) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_item.cmd == CMD_INSERT) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_OK;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else begin
                        if (w_found) begin
                            n_status = ST_OK;
                            n_count  = r_count - CNT_W'(1);
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // command kept for the shift cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
    end

    // head fields come straight from cell 0, which holds still while a result waits
    assign o_out_valid          = r_out_valid;
    assign o_out_data.status     = r_status;
    assign o_out_data.occupancy  = OCC_W'(r_count);
    assign o_out_data.head_valid = w_slot[0].valid;
    assign o_out_data.head_key   = w_slot[0].valid ? w_slot[0].key : '0;
    assign o_out_data.head_fast  = w_slot[0].valid && w_slot[0].fast;

endmodule

`default_nettype wire
